### hdl/sahtdr_pkg.sv
// ----------------------------------------------------------------------------
// sahtdr_pkg
// Entry layout, request and lookup result types and fixed constants of the
// set-associative hash table with depth-preferred replacement.
// ----------------------------------------------------------------------------
package sahtdr_pkg;

  localparam int ENTRY_W  = 64;
  localparam int TAG_W    = 22;
  localparam int TAG_LSB  = 42;
  localparam int DEPTH_W  = 8;
  localparam int GEN_W    = 2;
  localparam int SQ_W     = 6;
  localparam int PAY_W    = 20;
  localparam int PLY_W    = 7;
  localparam int HASH_W   = 64;
  localparam int SCORE_W  = 12;
  localparam int PEN_W    = 9;

  localparam logic [GEN_W-1:0]   NEW_GEN     = 2'd3;
  localparam logic [SCORE_W-1:0] START_SCORE = 12'sd1000;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // high field first: tag sits in [63:42], payload in [19:0]
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DEPTH_W-1:0] depth;
    logic [GEN_W-1:0]   gen;
    logic [SQ_W-1:0]    move_from;
    logic [SQ_W-1:0]    move_to;
    logic [PAY_W-1:0]   payload;
  } entry_t;

  typedef struct packed {
    logic               op;
    logic [TAG_W-1:0]   tag;
    logic [DEPTH_W-1:0] depth;
    logic [SQ_W-1:0]    move_from;
    logic [SQ_W-1:0]    move_to;
    logic [PAY_W-1:0]   payload;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [DEPTH_W-1:0] depth;
    logic [GEN_W-1:0]   gen;
    logic [SQ_W-1:0]    move_from;
    logic [SQ_W-1:0]    move_to;
    logic [PAY_W-1:0]   payload;
  } find_t;

endpackage

### hdl/sahtdr_ram.sv
// ----------------------------------------------------------------------------
// sahtdr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module sahtdr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sahtdr_bucket.sv
// ----------------------------------------------------------------------------
// sahtdr_bucket
// Bucket logic: parallel tag compare over all ways, first-match lookup
// result, move keeping on a match, lowest-score victim choice otherwise,
// and the modified bucket row for write-back.
// ----------------------------------------------------------------------------
module sahtdr_bucket #(
  parameter int WAYS = 4
) (
  input  logic [WAYS*sahtdr_pkg::ENTRY_W-1:0] row,
  input  sahtdr_pkg::req_t                    req,
  input  logic [sahtdr_pkg::PLY_W-1:0]        ply_weight,
  output sahtdr_pkg::find_t                   find,
  output logic [WAYS*sahtdr_pkg::ENTRY_W-1:0] wr_row
);
  import sahtdr_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  entry_t             ways [WAYS];
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  entry_t             hit_e;
  logic [WAY_W-1:0]   cand;
  logic [SCORE_W-1:0] cand_score;
  logic [SCORE_W-1:0] score [WAYS];
  logic [GEN_W-1:0]   age [WAYS];
  logic [PEN_W-1:0]   pen [WAYS];
  logic [WAY_W-1:0]   sel;
  entry_t             new_e;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ways[w]  = row[w*ENTRY_W +: ENTRY_W];
      age[w]   = NEW_GEN - ways[w].gen;
      pen[w]   = PEN_W'(ply_weight) * PEN_W'(age[w]);
      score[w] = SCORE_W'(ways[w].depth) - SCORE_W'({pen[w], 1'b0});
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    hit_e   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ways[w].tag == req.tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
        hit_e   = ways[w];
      end
    end
  end

  always_comb begin
    cand       = '0;
    cand_score = START_SCORE;
    for (int w = 0; w < WAYS; w++) begin
      if ($signed(score[w]) < $signed(cand_score)) begin
        cand       = WAY_W'(w);
        cand_score = score[w];
      end
    end
  end

  always_comb begin
    new_e.tag       = req.tag;
    new_e.depth     = req.depth;
    new_e.gen       = NEW_GEN;
    new_e.move_from = req.move_from;
    new_e.move_to   = req.move_to;
    new_e.payload   = req.payload;
    // keep the old move when the new entry brings none
    if (hit && hit_e.move_from != hit_e.move_to && req.move_from == req.move_to) begin
      new_e.move_from = hit_e.move_from;
      new_e.move_to   = hit_e.move_to;
    end
    sel    = hit ? hit_way : cand;
    wr_row = row;
    for (int w = 0; w < WAYS; w++) begin
      if (sel == WAY_W'(w)) begin
        wr_row[w*ENTRY_W +: ENTRY_W] = new_e;
      end
    end
  end

  always_comb begin
    find.hit       = hit;
    find.depth     = hit_e.depth;
    find.gen       = hit_e.gen;
    find.move_from = hit_e.move_from;
    find.move_to   = hit_e.move_to;
    find.payload   = hit_e.payload;
  end

endmodule

### hdl/set_assoc_hash_table_depth_replace_top.sv
// ----------------------------------------------------------------------------
// set_assoc_hash_table_depth_replace_top
// Set-associative hash table with depth-preferred replacement. One memory
// row holds a whole bucket; a request reads it and compares all ways at
// once, and an update writes the updated row back in the following cycle.
//
//   channel  dir  handshake            content
//   in_      in   in_tvalid/in_tready  tuser op, tdata hash..payload
//   out_     out  out_tvalid/out_tready tuser hit, tdata found fields
//   cfg_     in   cfg_valid/cfg_ready  ply_weight
//
// Each item runs a bucket row read, then compare and write-back or result
// load, the single read/write pass over the bucket memory; no new item is
// taken until it is done. After reset a clearing pass zeroes the memory;
// no item is taken until it ends. A lookup waits in the busy state while
// the output register holds an untaken result. Updates give no result.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_depth_replace_top #(
  parameter int BUCKETS = 65536,
  parameter int WAYS    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // op
  input  logic [103:0]                in_tdata,   // hash, depth, move_from, move_to, payload
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_tuser,  // hit
  output logic [47:0]                 out_tdata,  // depth, generation, move_from, move_to,
                                                  // payload, zero fill
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sahtdr_pkg::PLY_W-1:0] cfg_data
);
  import sahtdr_pkg::*;

  localparam int IDX_W = $clog2(BUCKETS);
  localparam int ROW_W = WAYS * ENTRY_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(BUCKETS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [PLY_W-1:0]  ply_r, ply_nxt;
  req_t              req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  find_t             out_r, out_nxt;

  logic              in_acc;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]  in_idx;
  find_t             find;
  logic [ROW_W-1:0]  wr_row;
  logic              out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign in_idx    = in_tdata[IDX_W-1:0] & IDX_MASK;

  sahtdr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  sahtdr_bucket #(
    .WAYS (WAYS)
  ) u_bucket (
    .row        (ram_rdata),
    .req        (req_r),
    .ply_weight (ply_r),
    .find       (find),
    .wr_row     (wr_row)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ply_nxt       = cfg_valid ? cfg_data : ply_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = wr_row;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_MASK) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt.op        = in_tuser;
          req_nxt.tag       = in_tdata[TAG_LSB +: TAG_W];
          req_nxt.depth     = in_tdata[64 +: DEPTH_W];
          req_nxt.move_from = in_tdata[72 +: SQ_W];
          req_nxt.move_to   = in_tdata[78 +: SQ_W];
          req_nxt.payload   = in_tdata[84 +: PAY_W];
          idx_nxt           = in_idx;
          state_nxt         = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (req_r.op == OP_UPDATE) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = find.hit ? find : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ply_r       <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ply_r       <= ply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.hit;
  assign out_tdata  = {6'b0, out_r.payload, out_r.move_to, out_r.move_from,
                       out_r.gen, out_r.depth};

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_BUSY)
    else $error("accepted item did not enter the bucket pass");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_CLEAR || (state_r == ST_BUSY && req_r.op == OP_UPDATE))
    else $error("bucket write outside clear or update");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_BUSY && $past(req_r.op) == OP_LOOKUP)
    else $error("result without a lookup");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready && !out_valid_r)
    else $error("traffic during clearing pass");

endmodule

### dv/set_assoc_hash_table_depth_replace_top_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_hash_table_depth_replace_top_tb
// Self-checking bench for the set-associative hash table. A queue-fed driver
// sends lookups and updates over the in_ stream, a shadow table in the bench
// predicts every lookup answer, and a monitor checks the out_ stream field
// by field. Phases change ply_weight and the idling of both sides.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_depth_replace_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sahtdr_pkg::*;

  localparam int BUCKETS     = 65536;
  localparam int WAYS        = 4;
  localparam int BUCKET_BITS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_BUCKETS   = 12;
  localparam int N_TAGS      = 8;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic              op;
    logic [HASH_W-1:0] hash;
    logic [DEPTH_W-1:0] depth;
    logic [SQ_W-1:0]   mv_from;
    logic [SQ_W-1:0]   mv_to;
    logic [PAY_W-1:0]  pay;
  } table_req_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic                in_tuser   = 1'b0;
  logic [103:0]        in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                out_tuser;
  logic [47:0]         out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [PLY_W-1:0]    cfg_data   = '0;

  table_req_t          pending_reqs[$];
  find_t               expected_finds[$];
  entry_t              shadow_entries[int];
  int                  shadow_ply = 1;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  logic [BUCKET_BITS-1:0] bucket_pool[N_BUCKETS];
  logic [TAG_W-1:0]    tag_pool[N_TAGS];

  set_assoc_hash_table_depth_replace_top #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic entry_t read_shadow(int slot);
    if (shadow_entries.exists(slot)) return shadow_entries[slot];
    return '0;
  endfunction

  // shadow of one table access; lookups queue their expected answer
  task automatic apply_request(table_req_t r);
    int     base;
    int     cand;
    int     cand_score;
    int     score;
    entry_t e;
    entry_t fresh;
    find_t  ans;
    logic [TAG_W-1:0] tag;
    base = int'(r.hash[BUCKET_BITS-1:0]) * WAYS;
    tag  = r.hash[HASH_W-1:TAG_LSB];
    if (r.op == OP_LOOKUP) begin
      ans = '0;
      for (int w = 0; w < WAYS; w++) begin
        e = read_shadow(base + w);
        if (e.tag == tag) begin
          ans.hit       = 1'b1;
          ans.depth     = e.depth;
          ans.gen       = e.gen;
          ans.move_from = e.move_from;
          ans.move_to   = e.move_to;
          ans.payload   = e.payload;
          break;
        end
      end
      expected_finds.push_back(ans);
      return;
    end
    fresh.tag       = tag;
    fresh.depth     = r.depth;
    fresh.gen       = NEW_GEN;
    fresh.move_from = r.mv_from;
    fresh.move_to   = r.mv_to;
    fresh.payload   = r.pay;
    cand       = 0;
    cand_score = int'(START_SCORE);
    for (int w = 0; w < WAYS; w++) begin
      e = read_shadow(base + w);
      if (e.tag == tag) begin
        // keep the stored move when the new entry carries none
        if (e.move_from != e.move_to && r.mv_from == r.mv_to) begin
          fresh.move_from = e.move_from;
          fresh.move_to   = e.move_to;
        end
        shadow_entries[base + w] = fresh;
        return;
      end
      score = int'(e.depth) - (int'(NEW_GEN) - int'(e.gen)) * shadow_ply * 2;
      if (score < cand_score) begin
        cand       = w;
        cand_score = score;
      end
    end
    shadow_entries[base + cand] = fresh;
  endtask

  // driver
  always @(posedge clk) begin
    table_req_t nxt;
    table_req_t sent;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent.op      = in_tuser;
        sent.hash    = in_tdata[63:0];
        sent.depth   = in_tdata[71:64];
        sent.mv_from = in_tdata[77:72];
        sent.mv_to   = in_tdata[83:78];
        sent.pay     = in_tdata[103:84];
        apply_request(sent);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_tuser  <= nxt.op;
          in_tdata  <= {nxt.pay, nxt.mv_to, nxt.mv_from, nxt.depth, nxt.hash};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    find_t exp_f;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_finds.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: hit %0b data %0h", out_tuser, out_tdata);
        end else begin
          exp_f = expected_finds.pop_front();
          check_field("hit", int'(exp_f.hit), int'(out_tuser));
          check_field("found_depth", int'(exp_f.depth), int'(out_tdata[7:0]));
          check_field("found_generation", int'(exp_f.gen), int'(out_tdata[9:8]));
          check_field("found_move_from", int'(exp_f.move_from),
                      int'(out_tdata[15:10]));
          check_field("found_move_to", int'(exp_f.move_to), int'(out_tdata[21:16]));
          check_field("found_payload", int'(exp_f.payload), int'(out_tdata[41:22]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic table_req_t make_req(logic op, logic [TAG_W-1:0] tag,
                                          logic [BUCKET_BITS-1:0] bucket,
                                          int depth, int mv_from, int mv_to, int pay);
    table_req_t r;
    r.op      = op;
    r.hash    = {tag, 26'($urandom), bucket};
    r.depth   = DEPTH_W'(depth);
    r.mv_from = SQ_W'(mv_from);
    r.mv_to   = SQ_W'(mv_to);
    r.pay     = PAY_W'(pay);
    return r;
  endfunction

  function automatic table_req_t random_req();
    table_req_t r;
    int         sel;
    r.op  = 1'($urandom_range(1));
    sel   = $urandom_range(9);
    r.depth = (sel == 0) ? '0 : (sel == 1) ? '1 : DEPTH_W'($urandom_range(255));
    r.mv_from = SQ_W'($urandom_range(63));
    r.mv_to   = ($urandom_range(2) == 0) ? r.mv_from : SQ_W'($urandom_range(63));
    r.pay     = PAY_W'($urandom_range(20'hFFFFF));
    if ($urandom_range(99) < 85)
      r.hash = {tag_pool[$urandom_range(N_TAGS-1)], 26'($urandom),
                bucket_pool[$urandom_range(N_BUCKETS-1)]};
    else
      r.hash = {$urandom, $urandom};
    return r;
  endfunction

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_tvalid || expected_finds.size() > 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ply(int value);
    cfg_data  <= PLY_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    shadow_ply = value;
  endtask

  task automatic run_phase(int ply, int send_pct, int recv_pct);
    wait_quiet();
    write_ply(ply);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (PHASE_ITEMS) pending_reqs.push_back(random_req());
  endtask

  initial begin
    bucket_pool[0] = '0;
    bucket_pool[1] = '1;
    for (int i = 2; i < N_BUCKETS; i++) bucket_pool[i] = BUCKET_BITS'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < N_TAGS; i++) tag_pool[i] = TAG_W'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-entry hit, miss, move keeping, bucket fill and eviction
    write_ply(1);
    pending_reqs.push_back(make_req(OP_LOOKUP, 22'h0, 16'h0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h1, 16'h0, 10, 1, 2, 20'hFFFFF));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h1, 16'h0, 20, 5, 5, 0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 22'h1, 16'h0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h1, 16'h0, 30, 7, 9, 20'h5A5A5));
    pending_reqs.push_back(make_req(OP_LOOKUP, 22'h1, 16'h0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h0, 16'h0, 255, 63, 0, 20'h12345));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h2, 16'h0, 0, 3, 3, 20'h1));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h3, 16'h0, 100, 0, 63, 20'h2));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h4, 16'h0, 200, 10, 11, 20'h3));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h5, 16'h0, 1, 12, 13, 20'h4));
    for (int t = 0; t < 6; t++)
      pending_reqs.push_back(make_req(OP_LOOKUP, TAG_W'(t), 16'h0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h3FFFFF, 16'hFFFF, 255, 63, 63,
                                    20'hFFFFF));
    pending_reqs.push_back(make_req(OP_UPDATE, 22'h3FFFFF, 16'hFFFF, 254, 63, 63, 0));
    pending_reqs.push_back('{OP_LOOKUP, '1, '1, '1, '1, '1});
    pending_reqs.push_back(make_req(OP_LOOKUP, 22'h0, 16'hFFFF, 0, 0, 0, 0));

    run_phase(64, 0, 0);
    run_phase(1, 65, 0);
    run_phase(127, 0, 65);
    run_phase(0, 30, 30);
    run_phase($urandom_range(1, 64), 30, 0);

    wait_quiet();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/sahtdr_pkg.sv
hdl/sahtdr_ram.sv
hdl/sahtdr_bucket.sv
hdl/set_assoc_hash_table_depth_replace_top.sv
dv/set_assoc_hash_table_depth_replace_top_tb.sv
